// ===== rtl/core/tnf_pkg.sv =====
// Shared types and constants for the triangle normal and tangent frame unit.
// Used by tnf_ctrl, tnf_datapath and triangle_normal_tangent_frame_unit; no dependencies.
package tnf_pkg;

  // One triangle corner request.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } corner_t;

  // One face frame result.
  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               uv_degenerate;
  } result_t;

  localparam int EPS_W = 25;
  localparam logic [EPS_W-1:0] EPS_RESET = 25'd17;

  // Datapath operation codes.
  localparam logic [4:0] OP_NOP    = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_EDGE   = 5'd2;
  localparam logic [4:0] OP_ESHIFT = 5'd3;
  localparam logic [4:0] OP_MUL    = 5'd4;
  localparam logic [4:0] OP_ACC    = 5'd5;
  localparam logic [4:0] OP_CSHIFT = 5'd6;
  localparam logic [4:0] OP_SQINIT = 5'd7;
  localparam logic [4:0] OP_SQSTEP = 5'd8;
  localparam logic [4:0] OP_DEGEN  = 5'd9;
  localparam logic [4:0] OP_DINIT  = 5'd10;
  localparam logic [4:0] OP_DSTEP  = 5'd11;
  localparam logic [4:0] OP_DEND   = 5'd12;
  localparam logic [4:0] OP_UMUL   = 5'd13;
  localparam logic [4:0] OP_UACC   = 5'd14;
  localparam logic [4:0] OP_OUT    = 5'd15;

  // Product selects for the shared 31x31 multiplier.
  localparam logic [3:0] K_X0A  = 4'd0;  // a1*a5
  localparam logic [3:0] K_X0B  = 4'd1;  // a2*a4
  localparam logic [3:0] K_X1A  = 4'd2;  // a2*a3
  localparam logic [3:0] K_X1B  = 4'd3;  // a0*a5
  localparam logic [3:0] K_X2A  = 4'd4;  // a0*a4
  localparam logic [3:0] K_X2B  = 4'd5;  // a1*a3
  localparam logic [3:0] K_SQ0  = 4'd6;
  localparam logic [3:0] K_SQ1  = 4'd7;
  localparam logic [3:0] K_SQ2  = 4'd8;
  localparam logic [3:0] K_DETA = 4'd9;  // du1*dv2
  localparam logic [3:0] K_DETB = 4'd10; // du2*dv1

  // Product selects for the edge by UV multiplier.
  localparam logic [3:0] U_TA = 4'd0; // e[i]*dv2
  localparam logic [3:0] U_TB = 4'd1; // e[3+i]*dv1
  localparam logic [3:0] U_BA = 4'd2; // e[3+i]*du1
  localparam logic [3:0] U_BB = 4'd3; // e[i]*du2

  // Divider source and destination selects.
  localparam logic [3:0] DSEL_NORMAL = 4'd0;
  localparam logic [3:0] DSEL_TAN    = 4'd1;
  localparam logic [3:0] DSEL_BITAN  = 4'd2;

  localparam logic [4:0] ITER_LAST = 5'd31;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] sel;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic e_big;
    logic c_shift;
  } stat_t;

endpackage

// ===== rtl/core/tnf_ctrl.sv =====
// Sequencer for the face frame unit: corner counting, operation sequencing, result valid.
// Depends on tnf_pkg; drives tnf_datapath through cmd_t and reads stat_t.
module tnf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  tnf_pkg::stat_t stat,
  output tnf_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EDGE   = 4'd1;
  localparam logic [3:0] S_ESHIFT = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_CSHIFT = 4'd5;
  localparam logic [3:0] S_SQINIT = 4'd6;
  localparam logic [3:0] S_SQRT   = 4'd7;
  localparam logic [3:0] S_DEGEN  = 4'd8;
  localparam logic [3:0] S_DINIT  = 4'd9;
  localparam logic [3:0] S_DSTEP  = 4'd10;
  localparam logic [3:0] S_DEND   = 4'd11;
  localparam logic [3:0] S_UMUL   = 4'd12;
  localparam logic [3:0] S_UACC   = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0] state, state_next;
  logic [1:0] corners, corners_next;
  logic [3:0] k, k_next;
  logic [4:0] iter, iter_next;
  logic [1:0] comp, comp_next;
  logic       kind, kind_next;
  logic       half, half_next;
  logic       tphase, tphase_next;
  logic       out_valid_next;
  logic [3:0] dsel;

  assign in_ready = (state == S_IDLE);
  assign dsel = tphase ? (kind ? tnf_pkg::DSEL_BITAN : tnf_pkg::DSEL_TAN)
                       : tnf_pkg::DSEL_NORMAL;

  always_comb begin
    state_next     = state;
    corners_next   = corners;
    k_next         = k;
    iter_next      = iter;
    comp_next      = comp;
    kind_next      = kind;
    half_next      = half;
    tphase_next    = tphase;
    out_valid_next = out_valid & ~out_ready;
    cmd            = '0;
    cmd.op         = tnf_pkg::OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op   = tnf_pkg::OP_LOAD;
          cmd.comp = corners;
          if (corners == 2'd2) begin
            corners_next = 2'd0;
            state_next   = S_EDGE;
          end else begin
            corners_next = corners + 2'd1;
          end
        end
      end
      S_EDGE: begin
        cmd.op     = tnf_pkg::OP_EDGE;
        state_next = S_ESHIFT;
      end
      S_ESHIFT: begin
        if (stat.e_big) begin
          cmd.op = tnf_pkg::OP_ESHIFT;
        end else begin
          k_next     = tnf_pkg::K_X0A;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op     = tnf_pkg::OP_MUL;
        cmd.sel    = k;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op  = tnf_pkg::OP_ACC;
        cmd.sel = k;
        k_next  = k + 4'd1;
        if (k == tnf_pkg::K_X2B) begin
          state_next = S_CSHIFT;
        end else if (k == tnf_pkg::K_DETB) begin
          state_next = S_SQINIT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_CSHIFT: begin
        if (stat.c_shift) begin
          cmd.op = tnf_pkg::OP_CSHIFT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_SQINIT: begin
        cmd.op     = tnf_pkg::OP_SQINIT;
        iter_next  = 5'd0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op    = tnf_pkg::OP_SQSTEP;
        iter_next = iter + 5'd1;
        if (iter == tnf_pkg::ITER_LAST) begin
          state_next = S_DEGEN;
        end
      end
      S_DEGEN: begin
        cmd.op      = tnf_pkg::OP_DEGEN;
        comp_next   = 2'd0;
        tphase_next = 1'b0;
        kind_next   = 1'b0;
        half_next   = 1'b0;
        state_next  = S_DINIT;
      end
      S_DINIT: begin
        cmd.op     = tnf_pkg::OP_DINIT;
        cmd.sel    = dsel;
        cmd.comp   = comp;
        iter_next  = 5'd0;
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op    = tnf_pkg::OP_DSTEP;
        iter_next = iter + 5'd1;
        if (iter == tnf_pkg::ITER_LAST) begin
          state_next = S_DEND;
        end
      end
      S_DEND: begin
        cmd.op   = tnf_pkg::OP_DEND;
        cmd.sel  = dsel;
        cmd.comp = comp;
        if (!tphase) begin
          if (comp == 2'd2) begin
            tphase_next = 1'b1;
            comp_next   = 2'd0;
            state_next  = S_UMUL;
          end else begin
            comp_next  = comp + 2'd1;
            state_next = S_DINIT;
          end
        end else if (!kind) begin
          kind_next  = 1'b1;
          state_next = S_UMUL;
        end else begin
          kind_next = 1'b0;
          if (comp == 2'd2) begin
            state_next = S_OUT;
          end else begin
            comp_next  = comp + 2'd1;
            state_next = S_UMUL;
          end
        end
      end
      S_UMUL: begin
        cmd.op     = tnf_pkg::OP_UMUL;
        cmd.sel    = {2'b00, kind, half};
        cmd.comp   = comp;
        state_next = S_UACC;
      end
      S_UACC: begin
        cmd.op   = tnf_pkg::OP_UACC;
        cmd.sel  = {2'b00, kind, half};
        cmd.comp = comp;
        if (!half) begin
          half_next  = 1'b1;
          state_next = S_UMUL;
        end else begin
          half_next  = 1'b0;
          state_next = S_DINIT;
        end
      end
      S_OUT: begin
        // The result register is only reloaded once the previous result has gone.
        if (!out_valid || out_ready) begin
          cmd.op         = tnf_pkg::OP_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      corners   <= 2'd0;
      k         <= 4'd0;
      iter      <= 5'd0;
      comp      <= 2'd0;
      kind      <= 1'b0;
      half      <= 1'b0;
      tphase    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      corners   <= corners_next;
      k         <= k_next;
      iter      <= iter_next;
      comp      <= comp_next;
      kind      <= kind_next;
      half      <= half_next;
      tphase    <= tphase_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/tnf_datapath.sv =====
// Datapath of the face frame unit: corner store, shared multipliers, square root and divider.
// Depends on tnf_pkg; sequenced by tnf_ctrl through cmd_t.
module tnf_datapath #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                      clk,
  input  tnf_pkg::cmd_t             cmd,
  input  tnf_pkg::corner_t          in_data,
  input  logic [tnf_pkg::EPS_W-1:0] det_epsilon,
  output tnf_pkg::stat_t            stat,
  output tnf_pkg::result_t          result
);

  localparam int EW  = COORD_WIDTH + 1;   // edge width
  localparam int UPW = EW + 17;           // edge by UV product
  localparam int NTW = COORD_WIDTH + 19;  // tangent numerator
  localparam int UNW = NTW + 12;          // scaled dividend magnitude
  localparam int NW  = NTW + 14;          // rounding dividend 2n+d
  localparam int DW  = 35;                // rounding divisor 2d

  // Corner store.
  logic signed [COORD_WIDTH-1:0] hp0 [3];
  logic signed [COORD_WIDTH-1:0] hp1 [3];
  logic signed [COORD_WIDTH-1:0] pc  [3];
  logic signed [15:0] ht0_u, ht0_v, ht1_u, ht1_v, cu, cv;
  logic [63:0] raw_ext [3];

  // Edges, scaled edges and UV differences.
  logic signed [EW-1:0] e [6];
  logic signed [EW-1:0] ed [6];
  logic [EW-1:0] a_mag [6];
  logic          a_neg [6];
  logic signed [30:0] a_s [6];
  logic signed [16:0] du1, dv1, du2, dv2;

  // Cross product, sum of squares, determinant.
  logic signed [30:0] ma, mb;
  logic signed [61:0] pmul, preg;
  logic signed [62:0] xtmp, xdiff;
  logic signed [34:0] ddiff;
  logic [61:0] c_mag [3];
  logic        c_neg [3];
  logic signed [30:0] c_s [3];
  logic [61:0] sum;
  logic [33:0] det_mag;
  logic        det_neg;
  logic        degen;
  logic        c_zero, c_big, c_small, e_big;

  // Square root.
  logic [63:0] sq_x, sq_r, sq_bit;

  // Edge by UV numerators.
  logic signed [EW-1:0]  e_lo, e_hi, ue;
  logic signed [16:0]    uv;
  logic signed [UPW-1:0] umul, uprod;
  logic signed [NTW-1:0] num;
  logic [NTW-1:0]        num_mag;

  // Divider.
  logic [UNW-1:0] dv_un;
  logic [33:0]    dv_ud;
  logic           dv_neg_in;
  logic [NW-1:0]  np, np_hi;
  logic [DW-1:0]  dp;
  logic [DW-1:0]  rem, dreg;
  logic [31:0]    lowsh, q;
  logic           dneg, dovf;
  logic [DW:0]    dt;
  logic           dge;
  logic [61:0]    cm_sel;
  logic           cn_sel;
  logic signed [32:0] qs;
  logic signed [15:0] nval;
  logic signed [31:0] tval;

  logic signed [15:0] nrm [3];
  logic signed [31:0] tng [3];
  logic signed [31:0] btg [3];

  always_comb begin
    raw_ext[0] = {32'b0, in_data.pos_x};
    raw_ext[1] = {32'b0, in_data.pos_y};
    raw_ext[2] = {32'b0, in_data.pos_z};
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ed[i]     = EW'(hp1[i]) - EW'(hp0[i]);
      ed[3 + i] = EW'(pc[i]) - EW'(hp0[i]);
    end
    for (int j = 0; j < 6; j++) begin
      a_s[j] = 31'(a_neg[j] ? -$signed({1'b0, a_mag[j]}) : $signed({1'b0, a_mag[j]}));
    end
    for (int i = 0; i < 3; i++) begin
      c_s[i] = 31'(c_neg[i] ? -$signed({1'b0, c_mag[i]}) : $signed({1'b0, c_mag[i]}));
    end
  end

  // Status: edges still too wide, cross product outside [2^29, 2^30).
  always_comb begin
    e_big   = 1'b0;
    c_zero  = 1'b1;
    c_big   = 1'b0;
    c_small = 1'b1;
    for (int j = 0; j < 6; j++) begin
      if ((a_mag[j] >> 30) != '0) e_big = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      if (c_mag[i] != '0) c_zero = 1'b0;
      if ((c_mag[i] >> 30) != '0) c_big = 1'b1;
      if ((c_mag[i] >> 29) != '0) c_small = 1'b0;
    end
    stat.e_big   = e_big;
    stat.c_shift = !c_zero && (c_big || c_small);
  end

  // Shared 31x31 multiplier operands.
  always_comb begin
    case (cmd.sel)
      tnf_pkg::K_X0A:  begin ma = a_s[1]; mb = a_s[5]; end
      tnf_pkg::K_X0B:  begin ma = a_s[2]; mb = a_s[4]; end
      tnf_pkg::K_X1A:  begin ma = a_s[2]; mb = a_s[3]; end
      tnf_pkg::K_X1B:  begin ma = a_s[0]; mb = a_s[5]; end
      tnf_pkg::K_X2A:  begin ma = a_s[0]; mb = a_s[4]; end
      tnf_pkg::K_X2B:  begin ma = a_s[1]; mb = a_s[3]; end
      tnf_pkg::K_SQ0:  begin ma = c_s[0]; mb = c_s[0]; end
      tnf_pkg::K_SQ1:  begin ma = c_s[1]; mb = c_s[1]; end
      tnf_pkg::K_SQ2:  begin ma = c_s[2]; mb = c_s[2]; end
      tnf_pkg::K_DETA: begin ma = 31'(du1); mb = 31'(dv2); end
      tnf_pkg::K_DETB: begin ma = 31'(du2); mb = 31'(dv1); end
      default:         begin ma = '0; mb = '0; end
    endcase
  end

  assign pmul  = ma * mb;
  assign xdiff = xtmp - 63'(preg);
  assign ddiff = 35'(xtmp) - 35'(preg);

  // Edge by UV multiplier operands.
  always_comb begin
    case (cmd.comp)
      2'd1:    begin e_lo = e[1]; e_hi = e[4]; end
      2'd2:    begin e_lo = e[2]; e_hi = e[5]; end
      default: begin e_lo = e[0]; e_hi = e[3]; end
    endcase
    case (cmd.sel)
      tnf_pkg::U_TA: begin ue = e_lo; uv = dv2; end
      tnf_pkg::U_TB: begin ue = e_hi; uv = dv1; end
      tnf_pkg::U_BA: begin ue = e_hi; uv = du1; end
      tnf_pkg::U_BB: begin ue = e_lo; uv = du2; end
      default:       begin ue = e_lo; uv = dv2; end
    endcase
  end

  assign umul    = ue * uv;
  assign num_mag = (num < 0) ? NTW'(-num) : NTW'(num);

  // Divider set-up: round half away from zero as floor((2n + d) / 2d).
  always_comb begin
    case (cmd.comp)
      2'd1:    begin cm_sel = c_mag[1]; cn_sel = c_neg[1]; end
      2'd2:    begin cm_sel = c_mag[2]; cn_sel = c_neg[2]; end
      default: begin cm_sel = c_mag[0]; cn_sel = c_neg[0]; end
    endcase
    if (cmd.sel == tnf_pkg::DSEL_NORMAL) begin
      dv_un     = UNW'({cm_sel[29:0], 14'b0});
      dv_ud     = {2'b00, sq_r[31:0]};
      dv_neg_in = cn_sel;
    end else if (degen) begin
      dv_un     = UNW'(num_mag);
      dv_ud     = 34'd4096;
      dv_neg_in = (num < 0);
    end else begin
      dv_un     = UNW'(num_mag) << 12;
      dv_ud     = det_mag;
      dv_neg_in = (num < 0) ^ det_neg;
    end
    np    = (NW'(dv_un) << 1) + NW'(dv_ud);
    dp    = {dv_ud, 1'b0};
    np_hi = np >> 32;
    dt    = {rem, lowsh[31]};
    dge   = (dt >= {1'b0, dreg});
  end

  // Result formatting with saturation of the quotient magnitude.
  always_comb begin
    qs   = dneg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    nval = c_zero ? 16'sd0 : 16'(qs);
    if (!dneg && (dovf || q[31])) begin
      tval = 32'h7fffffff;
    end else if (dneg && (dovf || (q > 32'h80000000))) begin
      tval = 32'h80000000;
    end else begin
      tval = 32'(qs);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tnf_pkg::OP_LOAD: begin
        case (cmd.comp)
          2'd0: begin
            for (int i = 0; i < 3; i++) hp0[i] <= raw_ext[i][COORD_WIDTH-1:0];
            ht0_u <= in_data.tex_u;
            ht0_v <= in_data.tex_v;
          end
          2'd1: begin
            for (int i = 0; i < 3; i++) hp1[i] <= raw_ext[i][COORD_WIDTH-1:0];
            ht1_u <= in_data.tex_u;
            ht1_v <= in_data.tex_v;
          end
          default: begin
            for (int i = 0; i < 3; i++) pc[i] <= raw_ext[i][COORD_WIDTH-1:0];
            cu <= in_data.tex_u;
            cv <= in_data.tex_v;
          end
        endcase
      end
      tnf_pkg::OP_EDGE: begin
        for (int j = 0; j < 6; j++) begin
          e[j]     <= ed[j];
          a_neg[j] <= (ed[j] < 0);
          a_mag[j] <= (ed[j] < 0) ? EW'(-ed[j]) : EW'(ed[j]);
        end
        du1 <= 17'(ht1_u) - 17'(ht0_u);
        dv1 <= 17'(ht1_v) - 17'(ht0_v);
        du2 <= 17'(cu) - 17'(ht0_u);
        dv2 <= 17'(cv) - 17'(ht0_v);
      end
      tnf_pkg::OP_ESHIFT: begin
        for (int j = 0; j < 6; j++) a_mag[j] <= a_mag[j] >> 1;
      end
      tnf_pkg::OP_MUL: begin
        preg <= pmul;
      end
      tnf_pkg::OP_ACC: begin
        case (cmd.sel)
          tnf_pkg::K_X0A, tnf_pkg::K_X1A, tnf_pkg::K_X2A, tnf_pkg::K_DETA: begin
            xtmp <= 63'(preg);
          end
          tnf_pkg::K_X0B, tnf_pkg::K_X1B, tnf_pkg::K_X2B: begin
            c_neg[cmd.sel[2:1]] <= (xdiff < 0);
            c_mag[cmd.sel[2:1]] <= (xdiff < 0) ? 62'(-xdiff) : 62'(xdiff);
          end
          tnf_pkg::K_SQ0: begin
            sum <= $unsigned(preg);
          end
          tnf_pkg::K_SQ1, tnf_pkg::K_SQ2: begin
            sum <= sum + $unsigned(preg);
          end
          tnf_pkg::K_DETB: begin
            det_neg <= (ddiff < 0);
            det_mag <= (ddiff < 0) ? 34'(-ddiff) : 34'(ddiff);
          end
          default: begin
            xtmp <= xtmp;
          end
        endcase
      end
      tnf_pkg::OP_CSHIFT: begin
        for (int i = 0; i < 3; i++) begin
          c_mag[i] <= c_big ? (c_mag[i] >> 1) : (c_mag[i] << 1);
        end
      end
      tnf_pkg::OP_SQINIT: begin
        sq_x   <= {2'b00, sum};
        sq_r   <= '0;
        sq_bit <= 64'h4000000000000000;
      end
      tnf_pkg::OP_SQSTEP: begin
        if (sq_x >= sq_r + sq_bit) begin
          sq_x <= sq_x - (sq_r + sq_bit);
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      tnf_pkg::OP_DEGEN: begin
        degen <= (det_mag == '0) || (det_mag < 34'(det_epsilon));
      end
      tnf_pkg::OP_DINIT: begin
        dovf  <= (np_hi >= NW'(dp));
        rem   <= DW'(np_hi);
        lowsh <= np[31:0];
        dreg  <= dp;
        dneg  <= dv_neg_in;
        q     <= '0;
      end
      tnf_pkg::OP_DSTEP: begin
        rem   <= dge ? DW'(dt - {1'b0, dreg}) : DW'(dt);
        lowsh <= lowsh << 1;
        q     <= {q[30:0], dge};
      end
      tnf_pkg::OP_DEND: begin
        case (cmd.sel)
          tnf_pkg::DSEL_NORMAL: nrm[cmd.comp] <= nval;
          tnf_pkg::DSEL_TAN:    tng[cmd.comp] <= tval;
          default:              btg[cmd.comp] <= tval;
        endcase
      end
      tnf_pkg::OP_UMUL: begin
        uprod <= umul;
      end
      tnf_pkg::OP_UACC: begin
        if (!cmd.sel[0]) begin
          num <= NTW'(uprod);
        end else begin
          num <= num - NTW'(uprod);
        end
      end
      tnf_pkg::OP_OUT: begin
        result.normal_x      <= nrm[0];
        result.normal_y      <= nrm[1];
        result.normal_z      <= nrm[2];
        result.tangent_x     <= tng[0];
        result.tangent_y     <= tng[1];
        result.tangent_z     <= tng[2];
        result.bitangent_x   <= btg[0];
        result.bitangent_y   <= btg[1];
        result.bitangent_z   <= btg[2];
        result.uv_degenerate <= degen;
      end
      default: begin
        preg <= preg;
      end
    endcase
  end

endmodule

// ===== rtl/core/triangle_normal_tangent_frame_unit.sv =====
// Top level of the triangle face normal and UV tangent frame unit.
// Depends on tnf_pkg, tnf_ctrl and tnf_datapath.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------
//   in      | in_valid / in_ready    | in_data   (corner_t)
//   out     | out_valid / out_ready  | out_data  (result_t)
//   cfg     | cfg_we (no wait)       | cfg_wdata (det_epsilon)
//
// The first two corners of a triangle are only stored. The third starts the face
// computation, which runs the single radix-2 divider through nine 32-step divisions,
// the 32-step square root and the one-bit normalising shifts.
// No request is accepted while a face is being computed; the result register lets the
// next triangle's corners in while the previous result waits for out_ready.
// Reset (rst, synchronous) clears the corner count and sets det_epsilon to 17.
module triangle_normal_tangent_frame_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tnf_pkg::corner_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tnf_pkg::result_t          out_data,
  input  logic                      cfg_we,
  input  logic [tnf_pkg::EPS_W-1:0] cfg_wdata
);

  logic [tnf_pkg::EPS_W-1:0] det_epsilon;
  tnf_pkg::cmd_t  cmd;
  tnf_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= tnf_pkg::EPS_RESET;
    end else if (cfg_we) begin
      det_epsilon <= cfg_wdata;
    end
  end

  tnf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  tnf_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .in_data     (in_data),
    .det_epsilon (det_epsilon),
    .stat        (stat),
    .result      (out_data)
  );

  // A corner is stored only when a request is actually accepted.
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.op == tnf_pkg::OP_LOAD |-> in_valid && in_ready)
    else $error("corner stored without an accepted request");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == tnf_pkg::OP_OUT |-> !out_valid || out_ready)
    else $error("result register reloaded while a result was pending");

  // While corners are being taken the arithmetic is idle.
  a_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> cmd.op == tnf_pkg::OP_NOP || cmd.op == tnf_pkg::OP_LOAD)
    else $error("datapath busy while accepting corners");

endmodule

// ===== verif/triangle_normal_tangent_frame_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for triangle_normal_tangent_frame_unit: random and directed corner
// streams, with results predicted in a scoreboard class and compared field by field.
// Depends on tnf_pkg and the RTL of the unit.
module triangle_normal_tangent_frame_unit_tb;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 600;

  class face_frame_board;
    longint held_pos[6];
    longint held_uv[4];
    int corners_held;
    logic [tnf_pkg::EPS_W-1:0] eps;
    tnf_pkg::result_t frames_due[$];
    int errors;

    function new();
      corners_held = 0;
      eps = tnf_pkg::EPS_RESET;
      errors = 0;
    endfunction

    function longint unsigned magn(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint with_sign(longint unsigned m, bit neg);
      return neg ? -longint'(m) : longint'(m);
    endfunction

    // Division rounded half away from zero.
    function longint div_round(longint n, longint d);
      longint unsigned un, ud;
      un = magn(n);
      ud = magn(d);
      return with_sign((2 * un + ud) / (2 * ud), (n < 0) != (d < 0));
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void unit_normal(longint e[6], output longint n[3]);
      longint a[6], c[3];
      longint unsigned m, sum, len;
      int s;
      m = 0;
      sum = 0;
      s = 0;
      for (int i = 0; i < 6; i++) if (magn(e[i]) > m) m = magn(e[i]);
      while ((m >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 6; i++) a[i] = with_sign(magn(e[i]) >> s, e[i] < 0);
      c[0] = a[1] * a[5] - a[2] * a[4];
      c[1] = a[2] * a[3] - a[0] * a[5];
      c[2] = a[0] * a[4] - a[1] * a[3];
      m = 0;
      for (int i = 0; i < 3; i++) if (magn(c[i]) > m) m = magn(c[i]);
      if (m == 0) begin
        n[0] = 0; n[1] = 0; n[2] = 0;
        return;
      end
      s = 0;
      if (m >= (64'd1 << 30)) begin
        while ((m >> s) >= (64'd1 << 30)) s++;
        for (int i = 0; i < 3; i++) c[i] = with_sign(magn(c[i]) >> s, c[i] < 0);
      end else begin
        while ((m << s) < (64'd1 << 29)) s++;
        for (int i = 0; i < 3; i++) c[i] = with_sign(magn(c[i]) << s, c[i] < 0);
      end
      for (int i = 0; i < 3; i++) sum += magn(c[i]) * magn(c[i]);
      len = root_floor(sum);
      for (int i = 0; i < 3; i++) n[i] = div_round(c[i] * 16384, longint'(len));
    endfunction

    function void note_corner(tnf_pkg::corner_t cr);
      longint p[3], e[6], n[3], u, v, du1, dv1, du2, dv2, det, nt, nb, t, b;
      bit flat_uv;
      tnf_pkg::result_t r;
      p[0] = longint'(cr.pos_x);
      p[1] = longint'(cr.pos_y);
      p[2] = longint'(cr.pos_z);
      u = longint'(cr.tex_u);
      v = longint'(cr.tex_v);
      if (corners_held < 2) begin
        for (int i = 0; i < 3; i++) held_pos[corners_held * 3 + i] = p[i];
        held_uv[corners_held * 2] = u;
        held_uv[corners_held * 2 + 1] = v;
        corners_held++;
        return;
      end
      corners_held = 0;
      for (int i = 0; i < 3; i++) begin
        e[i] = held_pos[3 + i] - held_pos[i];
        e[3 + i] = p[i] - held_pos[i];
      end
      unit_normal(e, n);
      du1 = held_uv[2] - held_uv[0];
      dv1 = held_uv[3] - held_uv[1];
      du2 = u - held_uv[0];
      dv2 = v - held_uv[1];
      det = du1 * dv2 - du2 * dv1;
      flat_uv = (det == 0) || (magn(det) < longint'(eps));
      r.normal_x = n[0][15:0];
      r.normal_y = n[1][15:0];
      r.normal_z = n[2][15:0];
      r.uv_degenerate = flat_uv;
      for (int i = 0; i < 3; i++) begin
        nt = e[i] * dv2 - e[3 + i] * dv1;
        nb = e[3 + i] * du1 - e[i] * du2;
        if (flat_uv) begin
          t = div_round(nt, 4096);
          b = div_round(nb, 4096);
        end else begin
          t = div_round(nt * 4096, det);
          b = div_round(nb * 4096, det);
        end
        t = clamp32(t);
        b = clamp32(b);
        case (i)
          0: begin r.tangent_x = t[31:0]; r.bitangent_x = b[31:0]; end
          1: begin r.tangent_y = t[31:0]; r.bitangent_y = b[31:0]; end
          default: begin r.tangent_z = t[31:0]; r.bitangent_z = b[31:0]; end
        endcase
      end
      frames_due = {frames_due, r};
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(tnf_pkg::result_t got);
      tnf_pkg::result_t w;
      if (frames_due.size() == 0) begin
        report("unexpected result, normal_x", longint'(got.normal_x), 0);
        return;
      end
      w = frames_due.pop_front();
      if (got.normal_x != w.normal_x) report("normal_x", got.normal_x, w.normal_x);
      if (got.normal_y != w.normal_y) report("normal_y", got.normal_y, w.normal_y);
      if (got.normal_z != w.normal_z) report("normal_z", got.normal_z, w.normal_z);
      if (got.tangent_x != w.tangent_x) report("tangent_x", got.tangent_x, w.tangent_x);
      if (got.tangent_y != w.tangent_y) report("tangent_y", got.tangent_y, w.tangent_y);
      if (got.tangent_z != w.tangent_z) report("tangent_z", got.tangent_z, w.tangent_z);
      if (got.bitangent_x != w.bitangent_x)
        report("bitangent_x", got.bitangent_x, w.bitangent_x);
      if (got.bitangent_y != w.bitangent_y)
        report("bitangent_y", got.bitangent_y, w.bitangent_y);
      if (got.bitangent_z != w.bitangent_z)
        report("bitangent_z", got.bitangent_z, w.bitangent_z);
      if (got.uv_degenerate != w.uv_degenerate)
        report("uv_degenerate", got.uv_degenerate, w.uv_degenerate);
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  tnf_pkg::corner_t in_data;
  logic out_valid;
  logic out_ready;
  tnf_pkg::result_t out_data;
  logic cfg_we;
  logic [tnf_pkg::EPS_W-1:0] cfg_wdata;

  face_frame_board board;
  int corners_taken;
  int cycles;
  bit quiet;
  bit gaps_on;

  triangle_normal_tangent_frame_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** triangle_normal_tangent_frame_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      board.note_corner(in_data);
      corners_taken = corners_taken + 1;
    end
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  // Receiver stalls come in bursts, with stretches of steady acceptance between them.
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  function automatic tnf_pkg::corner_t corner(int px, int py, int pz, int u, int v);
    tnf_pkg::corner_t c;
    c.pos_x = px;
    c.pos_y = py;
    c.pos_z = pz;
    c.tex_u = u[15:0];
    c.tex_v = v[15:0];
    return c;
  endfunction

  function automatic int span(int lim);
    return $signed($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Drives one corner request and returns once the unit has accepted it.
  task automatic send_corner(tnf_pkg::corner_t c);
    int target;
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    target = corners_taken + 1;
    wait (corners_taken == target);
  endtask

  task automatic write_eps(logic [tnf_pkg::EPS_W-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.eps = v;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_face(int kind);
    int p0[3], d[3], k, u0, v0;
    case (kind)
      0, 1, 2, 3: begin
        for (int i = 0; i < 3; i++)
          send_corner(corner($urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
      end
      4, 5: begin
        for (int i = 0; i < 3; i++)
          send_corner(corner(span(65536), span(65536), span(65536), span(8192), span(8192)));
      end
      6: begin
        // Collinear or coincident corners give a zero cross product.
        for (int i = 0; i < 3; i++) begin
          p0[i] = span(1 << 28);
          d[i] = span(1 << 20);
        end
        k = span(3);
        send_corner(corner(p0[0], p0[1], p0[2], span(4096), span(4096)));
        send_corner(corner(p0[0] + d[0], p0[1] + d[1], p0[2] + d[2], span(4096), span(4096)));
        send_corner(corner(p0[0] + k * d[0], p0[1] + k * d[1], p0[2] + k * d[2],
                           span(4096), span(4096)));
      end
      7: begin
        // Nearly coincident texture coordinates keep the determinant around the threshold.
        u0 = span(30000);
        v0 = span(30000);
        send_corner(corner($urandom(), $urandom(), $urandom(), u0, v0));
        send_corner(corner(span(1 << 24), span(1 << 24), span(1 << 24),
                           u0 + span(40), v0 + span(3)));
        send_corner(corner(span(1 << 24), span(1 << 24), span(1 << 24),
                           u0 + span(3), v0 + span(40)));
      end
      default: begin
        for (int i = 0; i < 3; i++)
          send_corner(corner(span(4), span(4), span(4), $urandom(), $urandom()));
      end
    endcase
  endtask

  initial begin
    board = new();
    corners_taken = 0;
    cycles = 0;
    quiet = 1'b0;
    gaps_on = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed faces: extreme positions and texture coordinates.
    send_corner(corner(32'h7fffffff, 32'h80000000, 0, 32767, -32768));
    send_corner(corner(32'h80000000, 32'h7fffffff, 32'h7fffffff, -32768, 32767));
    send_corner(corner(0, 32'h80000000, 32'h80000000, 0, 0));
    // All three corners coincide.
    for (int i = 0; i < 3; i++) send_corner(corner(1000, -2000, 3000, i * 100, i * i * 50));
    // Collinear corners.
    send_corner(corner(65536, 65536, 65536, 0, 0));
    send_corner(corner(131072, 131072, 131072, 4096, 0));
    send_corner(corner(196608, 196608, 196608, 0, 4096));
    // Identical texture coordinates give a zero determinant.
    send_corner(corner(0, 0, 0, 77, -77));
    send_corner(corner(65536, 0, 0, 77, -77));
    send_corner(corner(0, 65536, 0, 77, -77));
    // Determinant of one, below the reset threshold.
    send_corner(corner(0, 0, 0, 0, 0));
    send_corner(corner(65536, 0, 0, 1, 0));
    send_corner(corner(0, 65536, 0, 0, 1));
    // Determinant exactly at the threshold with long edges, so the tangent saturates.
    send_corner(corner(32'h80000000, 0, 32'h80000000, 0, 0));
    send_corner(corner(32'h7fffffff, 5, 0, 17, 0));
    send_corner(corner(0, 32'h7fffffff, 32'h7fffffff, 0, 1));
    // Tiny cross product, so the normal is shifted up.
    send_corner(corner(0, 0, 0, -4096, 0));
    send_corner(corner(1, 0, 0, 4096, 0));
    send_corner(corner(0, 1, 0, 0, 4096));
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_eps('0);
        1: write_eps(25'd16777216);
        2: write_eps(tnf_pkg::EPS_W'($urandom_range(1, 200)));
        3: write_eps(25'h1ffffff);
        default: write_eps(tnf_pkg::EPS_RESET);
      endcase
      for (int f = 0; f < 58; f++) begin
        if (f % 12 == 0) gaps_on = $urandom_range(0, 2) != 0;
        if (phase == 4 && f >= 40) quiet = 1'b1;
        send_face($urandom_range(0, 9));
      end
      settle();
    end

    if (board.errors == 0) begin
      $display("** triangle_normal_tangent_frame_unit: PASSED **");
    end else begin
      $display("** triangle_normal_tangent_frame_unit: FAILED **");
    end
    $finish;
  end

endmodule
